// ----- rtl/core/ysam_pkg.sv -----
package ysam_pkg;

  localparam int unsigned ONE_Q14 = 16384;

  // Configuration register widths and reset values
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd80;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 20'd53687;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3277;

  // Quotient bits of the normalizing divider; the quotient never exceeds ONE_Q14
  localparam int unsigned QUOT_W = 15;
  // Magnitude of a mixed side, which stays below 4 * ONE_Q14
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned ACC_W  = MAG_W + QUOT_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETPOINT_SCALE = 2'd0,
    REG_CORR_GAIN      = 2'd1,
    REG_CORR_LIMIT     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] setpoint_scale;
    logic [GAIN_W-1:0]  corr_gain;
    logic [LIMIT_W-1:0] corr_limit;
  } cfg_t;

  // Mixed left and right sides before normalization
  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] right;
  } mix_t;

  // One item inside the divider: both lanes share the divisor
  typedef struct packed {
    logic [MAG_W-1:0]   divisor;
    logic               norm;
    logic               left_neg;
    logic               right_neg;
    logic signed [15:0] left_raw;
    logic signed [15:0] right_raw;
    logic [ACC_W-1:0]   left_acc;
    logic [ACC_W-1:0]   right_acc;
  } div_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               norm;
  } res_t;

endpackage

// ----- rtl/core/ysam_mix.sv -----
module ysam_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ysam_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic signed [15:0]  throttle_cmd,
  input  logic signed [15:0]  turn_cmd,
  input  logic signed [15:0]  yaw_rate,
  output logic                out_valid,
  output ysam_pkg::mix_t      out_mix
);

  localparam logic signed [15:0] POS_ONE = 16'sd16384;
  localparam logic signed [15:0] NEG_ONE = -16'sd16384;

  function automatic logic signed [15:0] sat_one(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > POS_ONE) r = POS_ONE;
    else if (v < NEG_ONE) r = NEG_ONE;
    else r = v;
    return r;
  endfunction

  // Stage A: clamp commands, setpoint product
  logic                a_valid;
  logic signed [15:0]  a_thr, a_turn, a_rate;
  logic signed [33:0]  a_prod;
  logic signed [15:0]  thr_c, turn_c;
  logic signed [33:0]  sp_prod;

  assign thr_c   = sat_one(throttle_cmd);
  assign turn_c  = sat_one(turn_cmd);
  assign sp_prod = 34'(turn_c) * 34'($signed({1'b0, cfg.setpoint_scale}));

  // Stage B: rate error
  logic                b_valid;
  logic signed [15:0]  b_thr, b_turn;
  logic signed [17:0]  b_err;
  logic signed [17:0]  err;

  // setpoint = floor(prod / 2^14) fits 18 bits
  assign err = $signed(a_prod[31:14]) - 18'(a_rate);

  // Stage C: correction product
  logic                c_valid;
  logic signed [15:0]  c_thr, c_turn;
  logic signed [38:0]  c_prod;
  logic signed [38:0]  gain_prod;

  assign gain_prod = 39'(b_err) * 39'($signed({1'b0, cfg.corr_gain}));

  // Stage D: clamp correction, mix
  logic signed [22:0]  corr;
  logic signed [22:0]  lim_pos, lim_neg;
  logic signed [22:0]  corr_sat;
  logic signed [15:0]  corr_c;

  assign corr    = c_prod[38:16];
  assign lim_pos = $signed({8'd0, cfg.corr_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (corr > lim_pos) corr_sat = lim_pos;
    else if (corr < lim_neg) corr_sat = lim_neg;
    else corr_sat = corr;
  end

  assign corr_c = corr_sat[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_thr  <= thr_c;
      a_turn <= turn_c;
      a_rate <= yaw_rate;
      a_prod <= sp_prod;

      b_thr  <= a_thr;
      b_turn <= a_turn;
      b_err  <= err;

      c_thr  <= b_thr;
      c_turn <= b_turn;
      c_prod <= gain_prod;

      out_mix.left  <= 18'(c_thr) - 18'(c_turn) - 18'(corr_c);
      out_mix.right <= 18'(c_thr) + 18'(c_turn) + 18'(corr_c);
    end
  end

endmodule

// ----- rtl/core/ysam_div_step.sv -----
module ysam_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  ysam_pkg::div_t      in_item,
  output logic                out_valid,
  output ysam_pkg::div_t      out_item
);

  localparam int unsigned MW = ysam_pkg::MAG_W;
  localparam int unsigned QW = ysam_pkg::QUOT_W;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [ysam_pkg::ACC_W-1:0] step(
    input logic [ysam_pkg::ACC_W-1:0] acc,
    input logic [MW-1:0]              divisor
  );
    logic [MW:0]   shifted;
    logic          fits;
    logic [MW-1:0] rem_next;
    shifted  = {acc[ysam_pkg::ACC_W-1:QW], acc[QW-1]};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? MW'(shifted - {1'b0, divisor}) : shifted[MW-1:0];
    return {rem_next, acc[QW-2:0], fits};
  endfunction

  ysam_pkg::div_t item_next;

  always_comb begin
    item_next           = in_item;
    item_next.left_acc  = step(in_item.left_acc, in_item.divisor);
    item_next.right_acc = step(in_item.right_acc, in_item.divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ----- rtl/core/ysam_norm.sv -----
module ysam_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  ysam_pkg::mix_t      in_mix,
  output logic                out_valid,
  output ysam_pkg::res_t      out_res
);

  localparam int unsigned MW = ysam_pkg::MAG_W;
  localparam int unsigned QW = ysam_pkg::QUOT_W;
  localparam int unsigned DW = MW + 14;

  function automatic logic [MW-1:0] mag(input logic signed [17:0] v);
    logic signed [17:0] a;
    a = v[17] ? -v : v;
    return a[MW-1:0];
  endfunction

  // Stage E: larger magnitude, rounded dividends
  logic [MW-1:0] mag_l, mag_r, m;
  logic [DW-1:0] dvd_l, dvd_r;

  assign mag_l = mag(in_mix.left);
  assign mag_r = mag(in_mix.right);
  assign m     = (mag_r > mag_l) ? mag_r : mag_l;
  assign dvd_l = {mag_l, 14'd0} + DW'(m >> 1);
  assign dvd_r = {mag_r, 14'd0} + DW'(m >> 1);

  logic             e_valid;
  ysam_pkg::div_t   e_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_item.divisor   <= m;
      e_item.norm      <= m > MW'(ysam_pkg::ONE_Q14);
      e_item.left_neg  <= in_mix.left[17];
      e_item.right_neg <= in_mix.right[17];
      e_item.left_raw  <= in_mix.left[15:0];
      e_item.right_raw <= in_mix.right[15:0];
      e_item.left_acc  <= ysam_pkg::ACC_W'(dvd_l);
      e_item.right_acc <= ysam_pkg::ACC_W'(dvd_r);
    end
  end

  // Divider stages, one quotient bit each
  logic           st_valid [QW+1];
  ysam_pkg::div_t st_item  [QW+1];

  assign st_valid[0] = e_valid;
  assign st_item[0]  = e_item;

  for (genvar i = 0; i < QW; i++) begin : g_div
    ysam_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (st_valid[i]),
      .in_item   (st_item[i]),
      .out_valid (st_valid[i+1]),
      .out_item  (st_item[i+1])
    );
  end

  // Apply sign to quotient, or pass the mix through when in range
  logic [15:0] q_l, q_r;

  assign q_l = 16'(st_item[QW].left_acc[QW-1:0]);
  assign q_r = 16'(st_item[QW].right_acc[QW-1:0]);

  assign out_valid    = st_valid[QW];
  assign out_res.norm = st_item[QW].norm;

  always_comb begin
    if (st_item[QW].norm) begin
      out_res.left  = st_item[QW].left_neg  ? -$signed(q_l) : $signed(q_l);
      out_res.right = st_item[QW].right_neg ? -$signed(q_r) : $signed(q_r);
    end else begin
      out_res.left  = st_item[QW].left_raw;
      out_res.right = st_item[QW].right_raw;
    end
  end

endmodule

// ----- rtl/core/yaw_assisted_arcade_mixer.sv -----
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: throttle_cmd, turn_cmd, yaw_rate
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: left_drive, right_drive;
//                                              tuser: was_normalized
// cfg      in   cfg_we                         cfg_index, cfg_wdata
//
// One transaction per cycle sustained while m_axis_tready keeps the output moving.
// Depth is set by the 15-stage restoring divider (one quotient bit per stage) plus
// four multiply/mix stages, one magnitude stage and the output register.
// rst is synchronous and clears all valid bits; configuration returns to defaults.
// A stalled output parks one result in a skid register; input stalls while it is full.
module yaw_assisted_arcade_mixer (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] throttle_cmd, [31:16] turn_cmd, [47:32] yaw_rate

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] left_drive, [31:16] right_drive
  output logic        m_axis_tuser,   // [0] was_normalized

  input  logic                                cfg_we,
  input  logic [ysam_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ysam_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ysam_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint_scale <= ysam_pkg::SCALE_RESET;
      cfg.corr_gain      <= ysam_pkg::GAIN_RESET;
      cfg.corr_limit     <= ysam_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (ysam_pkg::cfg_reg_t'(cfg_index))
        ysam_pkg::REG_SETPOINT_SCALE:
          cfg.setpoint_scale <= cfg_wdata[ysam_pkg::SCALE_W-1:0];
        ysam_pkg::REG_CORR_GAIN:
          cfg.corr_gain      <= cfg_wdata[ysam_pkg::GAIN_W-1:0];
        ysam_pkg::REG_CORR_LIMIT:
          cfg.corr_limit     <= cfg_wdata[ysam_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic           pipe_en;
  logic           mix_valid;
  ysam_pkg::mix_t mix;
  logic           res_valid;
  ysam_pkg::res_t res;

  logic           skid_valid;
  ysam_pkg::res_t skid;
  ysam_pkg::res_t out;

  // Advance the whole pipeline whenever the skid slot is free
  assign pipe_en       = !skid_valid;
  assign s_axis_tready = pipe_en;

  ysam_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .en           (pipe_en),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .throttle_cmd (s_axis_tdata[15:0]),
    .turn_cmd     (s_axis_tdata[31:16]),
    .yaw_rate     (s_axis_tdata[47:32]),
    .out_valid    (mix_valid),
    .out_mix      (mix)
  );

  ysam_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (mix_valid),
    .in_mix    (mix),
    .out_valid (res_valid),
    .out_res   (res)
  );

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= res_valid;
      end
    end else if (res_valid && pipe_en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out <= skid_valid ? skid : res;
    end else if (pipe_en) begin
      skid <= res;
    end
  end

  assign m_axis_tdata = {out.right, out.left};
  assign m_axis_tuser = out.norm;

  // A result in the skid slot always has one ahead of it at the output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid holds a result while output is empty");

  // Input only backs up when a result is waiting downstream
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending result");

  // A rescaled result has its larger side at exactly full scale
  a_norm_full_scale: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      out.left == 16'sd16384 || out.left == -16'sd16384 ||
      out.right == 16'sd16384 || out.right == -16'sd16384)
    else $error("normalized result not at full scale");

  // Every result stays within plus or minus one
  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      out.left <= 16'sd16384 && out.left >= -16'sd16384 &&
      out.right <= 16'sd16384 && out.right >= -16'sd16384)
    else $error("drive output out of range");

endmodule
